// File: hdl/efv_pkg.sv
// Shared types, constants and step routing for the single-precision erfinv unit.
package efv_pkg;

  // Pipeline geometry
  localparam int NumCells  = 23;
  localparam int CellDepth = 6;

  // Double pattern to single pattern, round to nearest even (elaboration only)
  function automatic logic [31:0] sp_of(real v);
    logic [63:0] d;
    logic [10:0] eb;
    logic        up;
    d  = $realtobits(v);
    eb = d[62:52] - 11'd896;
    up = d[28] & ((|d[27:0]) | d[29]);
    return {d[63], eb[7:0], d[51:29]} + {31'b0, up};
  endfunction

  localparam logic [31:0] One      = 32'h3F800000;
  localparam logic [31:0] NegOne   = 32'hBF800000;
  localparam logic [31:0] NegZero  = 32'h80000000;
  localparam logic [31:0] NegHalf  = 32'hBF000000;
  localparam logic [31:0] QNan     = 32'h7FC00000;
  localparam logic [31:0] PosInf   = 32'h7F800000;
  localparam logic [31:0] BrkLim   = 32'h40C40000;
  localparam logic [31:0] FoldLim  = sp_of(0.666666667);
  localparam logic [31:0] Ln2      = sp_of(0.693147182);
  localparam logic [31:0] LogR0    = sp_of(-0.130310059);
  localparam logic [31:0] LogT0    = sp_of(0.140869141);
  localparam logic [31:0] LogR1    = sp_of(-0.121484190);
  localparam logic [31:0] LogT1    = sp_of(0.139814854);
  localparam logic [31:0] LogR2    = sp_of(-0.166846052);
  localparam logic [31:0] LogT2    = sp_of(0.200120345);
  localparam logic [31:0] LogR3    = sp_of(-0.249996200);
  localparam logic [31:0] LogC3    = sp_of(0.333331972);
  localparam logic [31:0] TailInit = sp_of(5.43877832e-9);

  // Context that travels with every beat through the cell row
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] r;
    logic [31:0] u;
    logic [31:0] m;
    logic [31:0] s;
    logic [31:0] i;
    logic        brk;
    logic        spc;
    logic [31:0] spc_bits;
  } ctx_t;

  // Operands of one fused multiply-add: x * y + z
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } ops_t;

  // Polynomial addends, j-th step; brk selects the wide-argument branch
  function automatic logic [31:0] coef(int j, logic brk);
    logic [31:0] c;
    case (j)
      0: c = brk ? sp_of(3.03697567e-10) : sp_of(1.43285448e-7);
      1: c = brk ? sp_of(2.93243101e-8)  : sp_of(1.22774793e-6);
      2: c = brk ? sp_of(1.22150334e-6)  : sp_of(1.12963626e-7);
      3: c = brk ? sp_of(2.84108955e-5)  : sp_of(-5.61530760e-5);
      4: c = brk ? sp_of(3.93552968e-4)  : sp_of(-1.47697632e-4);
      5: c = brk ? sp_of(3.02698812e-3)  : sp_of(2.31468678e-3);
      6: c = brk ? sp_of(4.83185798e-3)  : sp_of(1.15392581e-2);
      7: c = brk ? sp_of(-2.64646143e-1) : sp_of(-2.32015476e-1);
      8: c = brk ? sp_of(8.40016484e-1)  : sp_of(8.86226892e-1);
      default: c = '0;
    endcase
    return c;
  endfunction

  // Small signed integer to single precision (exact)
  function automatic logic [31:0] i2f(logic signed [8:0] e);
    logic [8:0]  mag;
    logic [31:0] sh;
    int          p;
    mag = e[8] ? 9'(-e) : 9'(e);
    p = 0;
    for (int j = 0; j < 9; j++) begin
      if (mag[j]) p = j;
    end
    sh = 32'({23'b0, mag}) << (23 - p);
    if (mag == 9'd0) return 32'h0;
    return {e[8], 8'(127 + p), sh[22:0]};
  endfunction

  // Store the result of step k into the context
  function automatic ctx_t write_back(int k, ctx_t cin, logic [31:0] res);
    ctx_t              c;
    logic [31:0]       mb;
    logic signed [8:0] e;
    c  = cin;
    mb = {9'h07E, res[22:0]};
    e  = $signed({1'b0, res[30:23]}) - 9'sd126;
    case (k)
      0: begin
        // split into exponent and a mantissa folded into [2/3, 4/3)
        c.r = res;
        if (mb < FoldLim) begin
          mb = {9'h07F, res[22:0]};
          e  = e - 9'sd1;
        end
        c.m = mb;
        c.i = i2f(e);
      end
      1: c.m = res;
      2: c.s = res;
      4, 6: c.u = res;
      12: begin
        c.u   = res;
        c.brk = res[30:0] > BrkLim[30:0];
        c.r   = (res[30:0] > BrkLim[30:0]) ? 32'h0 : TailInit;
      end
      default: c.r = res;
    endcase
    return c;
  endfunction

  // Operands of step k taken from the context
  function automatic ops_t operands(int k, ctx_t c);
    ops_t o;
    case (k)
      0:  o = '{x: c.a, y: {~c.a[31], c.a[30:0]}, z: One};
      1:  o = '{x: c.m, y: One, z: NegOne};
      2:  o = '{x: c.m, y: c.m, z: NegZero};
      3:  o = '{x: LogR0, y: c.s, z: LogR1};
      4:  o = '{x: LogT0, y: c.s, z: LogT1};
      5:  o = '{x: c.r, y: c.s, z: LogR2};
      6:  o = '{x: c.u, y: c.s, z: LogT2};
      7:  o = '{x: c.r, y: c.s, z: LogR3};
      8:  o = '{x: c.u, y: c.m, z: c.r};
      9:  o = '{x: c.r, y: c.m, z: LogC3};
      10: o = '{x: c.r, y: c.m, z: NegHalf};
      11: o = '{x: c.r, y: c.s, z: c.m};
      12: o = '{x: c.i, y: Ln2, z: c.r};
      22: o = '{x: c.a, y: c.r, z: NegZero};
      default: o = '{x: c.r, y: c.u, z: coef(k - 13, c.brk)};
    endcase
    return o;
  endfunction

endpackage

// File: hdl/efv_fma_cell.sv
// One cell of the row: a six-stage binary32 fused multiply-add with context carry.
module efv_fma_cell import efv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        vld_i,
  input  ops_t        ops_i,
  input  ctx_t        ctx_i,
  output logic        hold_o,
  output logic        vld_o,
  output logic [31:0] res_o,
  output ctx_t        ctx_o,
  input  logic        hold_i
);

  logic [CellDepth-1:0] v_q;
  logic [CellDepth-1:0] h;
  ctx_t                 ctx_q [CellDepth];

  // Per-stage hold: a stage waits only when it is full and the next one waits
  always_comb begin
    h[CellDepth-1] = v_q[CellDepth-1] & hold_i;
    for (int j = CellDepth - 2; j >= 0; j--) begin
      h[j] = v_q[j] & h[j+1];
    end
  end
  assign hold_o = h[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (!h[0]) v_q[0] <= vld_i;
      for (int j = 1; j < CellDepth; j++) begin
        if (!h[j]) v_q[j] <= v_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!h[0]) ctx_q[0] <= ctx_i;
    for (int j = 1; j < CellDepth; j++) begin
      if (!h[j]) ctx_q[j] <= ctx_q[j-1];
    end
  end

  // Stage 1: unpack and multiply mantissas
  logic [7:0]  xe, ye, ze, xe_e, ye_e, ze_e;
  logic [23:0] xm, ym, zm;
  logic [47:0] prod_q;
  logic [23:0] zm_q;
  logic [31:0] zraw_q;
  logic signed [10:0] lp_q, lz_q;
  logic ps_q, pz_q, zz_q;

  always_comb begin
    xe   = ops_i.x[30:23];
    ye   = ops_i.y[30:23];
    ze   = ops_i.z[30:23];
    xe_e = (xe == 8'd0) ? 8'd1 : xe;
    ye_e = (ye == 8'd0) ? 8'd1 : ye;
    ze_e = (ze == 8'd0) ? 8'd1 : ze;
    xm   = {|xe, ops_i.x[22:0]};
    ym   = {|ye, ops_i.y[22:0]};
    zm   = {|ze, ops_i.z[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (!h[0]) begin
      prod_q <= xm * ym;
      ps_q   <= ops_i.x[31] ^ ops_i.y[31];
      pz_q   <= (xm == 24'd0) | (ym == 24'd0);
      lp_q   <= $signed({3'b0, xe_e}) + $signed({3'b0, ye_e}) - 11'sd300;
      zm_q   <= zm;
      zz_q   <= (zm == 24'd0);
      lz_q   <= $signed({3'b0, ze_e}) - 11'sd174;
      zraw_q <= ops_i.z;
    end
  end

  // Stage 2: align the smaller term with sticky, then add or subtract
  logic               sel, effsub, bsign, neg;
  logic signed [10:0] dlt, lbig;
  logic [6:0]         ash;
  logic [47:0]        big_m, small_m;
  logic [227:0]       wide;
  logic [100:0]       big_f, small_f;
  logic [101:0]       sum_w, mag_w;
  logic [99:0]        mag2_q;
  logic signed [10:0] lb2_q;
  logic               sg2_q, byp2_q;
  logic [31:0]        bb2_q;

  always_comb begin
    sel     = zz_q | (lp_q >= lz_q);
    dlt     = sel ? (lp_q - lz_q) : (lz_q - lp_q);
    ash     = (dlt > 11'sd127) ? 7'd127 : dlt[6:0];
    big_m   = sel ? prod_q : {zm_q, 24'b0};
    small_m = sel ? {zm_q, 24'b0} : prod_q;
    lbig    = sel ? lp_q : lz_q;
    wide    = {2'b0, small_m, 50'b0, 128'b0} >> ash;
    big_f   = {2'b0, big_m, 51'b0};
    small_f = {wide[227:128], |wide[127:0]};
    effsub  = ps_q ^ zraw_q[31];
    bsign   = sel ? ps_q : zraw_q[31];
    sum_w   = effsub ? ({1'b0, big_f} - {1'b0, small_f}) : ({1'b0, big_f} + {1'b0, small_f});
    neg     = effsub & sum_w[101];
    mag_w   = neg ? (~sum_w + 102'd1) : sum_w;
  end

  always_ff @(posedge clk_i) begin
    if (!h[1]) begin
      mag2_q <= mag_w[99:0];
      sg2_q  <= bsign ^ neg;
      lb2_q  <= lbig;
      byp2_q <= pz_q;
      bb2_q  <= zz_q ? {ps_q & zraw_q[31], 31'b0} : zraw_q;
    end
  end

  // Stage 3: leading-zero count of each 16-bit chunk
  logic [111:0] v112;
  logic [15:0]  chunk;
  logic [6:0]   nz;
  logic [3:0]   cl [7];
  logic [99:0]  mag3_q;
  logic [6:0]   nz3_q;
  logic [3:0]   cl3_q [7];
  logic signed [10:0] lb3_q;
  logic         sg3_q, byp3_q;
  logic [31:0]  bb3_q;

  always_comb begin
    v112 = {mag2_q, 12'b0};
    for (int c = 0; c < 7; c++) begin
      chunk = v112[111 - 16*c -: 16];
      nz[c] = |chunk;
      cl[c] = 4'd0;
      for (int j = 0; j < 16; j++) begin
        if (chunk[j]) cl[c] = 4'(15 - j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!h[2]) begin
      mag3_q <= mag2_q;
      nz3_q  <= nz;
      cl3_q  <= cl;
      lb3_q  <= lb2_q;
      sg3_q  <= sg2_q;
      byp3_q <= byp2_q;
      bb3_q  <= bb2_q;
    end
  end

  // Stage 4: total count, result exponent and shift amount
  logic [6:0]         lz;
  logic               zro, nrm;
  logic signed [11:0] ex_w, sub_w;
  logic [99:0]        mag4_q;
  logic signed [8:0]  sh4_q;
  logic [7:0]         ef4_q;
  logic               ovf4_q, zro4_q, sg4_q, byp4_q;
  logic [31:0]        bb4_q;

  always_comb begin
    lz  = 7'd0;
    zro = 1'b1;
    for (int c = 6; c >= 0; c--) begin
      if (nz3_q[c]) begin
        lz  = 7'(16*c) + {3'b0, cl3_q[c]};
        zro = 1'b0;
      end
    end
    ex_w  = $signed({lb3_q[10], lb3_q}) + 12'sd175 - $signed({5'b0, lz});
    sub_w = $signed({lb3_q[10], lb3_q}) + 12'sd174;
    nrm   = ex_w >= 12'sd1;
  end

  always_ff @(posedge clk_i) begin
    if (!h[3]) begin
      mag4_q <= mag3_q;
      sh4_q  <= nrm ? $signed({2'b0, lz}) : sub_w[8:0];
      ef4_q  <= nrm ? ex_w[7:0] : 8'd0;
      ovf4_q <= nrm & (ex_w >= 12'sd255);
      zro4_q <= zro;
      sg4_q  <= sg3_q;
      byp4_q <= byp3_q;
      bb4_q  <= bb3_q;
    end
  end

  // Stage 5: normalizing or denormalizing shift
  logic [8:0]   nsh;
  logic [227:0] rw;
  logic [99:0]  norm;
  logic         xst;
  logic [22:0]  mt5_q;
  logic [7:0]   ef5_q;
  logic         g5_q, st5_q, ovf5_q, zro5_q, sg5_q, byp5_q;
  logic [31:0]  bb5_q;

  always_comb begin
    nsh = 9'(-sh4_q);
    rw  = {mag4_q, 128'b0} >> nsh[6:0];
    if (!sh4_q[8]) begin
      norm = mag4_q << sh4_q[6:0];
      xst  = 1'b0;
    end else begin
      norm = rw[227:128];
      xst  = |rw[127:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!h[4]) begin
      mt5_q  <= norm[98:76];
      g5_q   <= norm[75];
      st5_q  <= (|norm[74:0]) | xst;
      ef5_q  <= ef4_q;
      ovf5_q <= ovf4_q;
      zro5_q <= zro4_q;
      sg5_q  <= sg4_q;
      byp5_q <= byp4_q;
      bb5_q  <= bb4_q;
    end
  end

  // Stage 6: round to nearest even and pack
  logic        up;
  logic [30:0] pk;
  logic [31:0] res_d, res_q;

  always_comb begin
    up = g5_q & (st5_q | mt5_q[0]);
    pk = {ef5_q, mt5_q} + {30'b0, up};
    if (byp5_q)      res_d = bb5_q;
    else if (zro5_q) res_d = 32'h0;
    else if (ovf5_q) res_d = {sg5_q, PosInf[30:0]};
    else             res_d = {sg5_q, pk};
  end

  always_ff @(posedge clk_i) begin
    if (!h[5]) res_q <= res_d;
  end

  assign vld_o = v_q[CellDepth-1];
  assign res_o = res_q;
  assign ctx_o = ctx_q[CellDepth-1];

endmodule

// File: hdl/erfinv_single_precision_unit.sv
// An accepted input beat passes through the cell row and then the output register to its result beat.
// Throughput: one beat per cycle while the output is not stalled; 23 fused multiply-add cells of 6 stages each.
// Each stage holds only when it is full and its successor holds, so bubbles close up.
// Reset (rst_ni low, asynchronous) clears all valid flags; payload is not reset.
module erfinv_single_precision_unit import efv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] operand_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_bits_o
);

  ctx_t        cin  [NumCells];
  ctx_t        cout [NumCells];
  ops_t        ops  [NumCells];
  logic [31:0] res  [NumCells];
  logic        vin  [NumCells];
  logic        vout [NumCells];
  logic        hin  [NumCells];
  logic        hout [NumCells];
  ctx_t        entry;
  logic [30:0] mag;

  // Special operands are decided at entry and ride along with the beat
  always_comb begin
    mag            = operand_bits_i[30:0];
    entry          = '0;
    entry.a        = operand_bits_i;
    entry.spc      = 1'b1;
    if (mag > PosInf[30:0])   entry.spc_bits = operand_bits_i | 32'h00400000;
    else if (mag > One[30:0]) entry.spc_bits = QNan;
    else if (mag == One[30:0]) entry.spc_bits = {operand_bits_i[31], PosInf[30:0]};
    else                       entry.spc = 1'b0;
  end

  // Row of cells with step routing between neighbors
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign cin[k] = entry;
      assign vin[k] = in_valid_i;
    end else begin : g_next
      assign cin[k]    = write_back(k - 1, cout[k-1], res[k-1]);
      assign vin[k]    = vout[k-1];
      assign hin[k-1]  = hout[k];
    end
    assign ops[k] = operands(k, cin[k]);

    efv_fma_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vin[k]),
      .ops_i  (ops[k]),
      .ctx_i  (cin[k]),
      .hold_o (hout[k]),
      .vld_o  (vout[k]),
      .res_o  (res[k]),
      .ctx_o  (cout[k]),
      .hold_i (hin[k])
    );
  end

  assign in_stall_o = hout[0];

  // Output register
  logic        out_valid_q;
  logic [31:0] out_bits_q;
  logic        out_hold;

  assign out_hold           = out_valid_q & out_stall_i;
  assign hin[NumCells-1]    = out_hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= vout[NumCells-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_hold) begin
      out_bits_q <= cout[NumCells-1].spc ? cout[NumCells-1].spc_bits : res[NumCells-1];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_bits_o = out_bits_q;

endmodule

// File: hdl/efv_checker.sv
// Port-level checker for the erfinv unit, bound to the top level.
module efv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] operand_bits_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_bits_o
);

  logic [7:0] cnt_q, cnt_d;
  logic       in_beat, out_beat;

  // Beats in flight
  assign in_beat  = in_valid_i & !in_stall_o;
  assign out_beat = out_valid_o & !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_beat & !out_beat) cnt_d = cnt_q + 8'd1;
    if (!in_beat & out_beat) cnt_d = cnt_q - 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(result_bits_o))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q != 8'd0)
    else $error("result beat without a pending input beat");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result waiting");

  logic unused_ok;
  assign unused_ok = ^operand_bits_i;

endmodule

bind erfinv_single_precision_unit efv_checker u_efv_checker (.*);

// File: bench/tb_top.sv
// Self-checking bench for the single-precision inverse error function unit.
`timescale 1ns / 100ps

module tb_top;
  import efv_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] operand_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_bits_o;

  logic [31:0] operand_q[$];
  logic [31:0] erfinv_q[$];
  int          errors = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          wide_hits = 0;
  bit          beat_taken = 0;
  bit          no_idle = 0;
  bit          hold_req = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_cnt = 0;

  erfinv_single_precision_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .operand_bits_i,
    .out_valid_o, .out_stall_i, .result_bits_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // binary32 pattern to real (exact)
  function automatic real sp_to_real(logic [31:0] b);
    logic [63:0] d;
    real         v;
    if (b[30:23] == 8'd0) begin
      v = real'(b[22:0]) * (2.0 ** (-149));
      return b[31] ? -v : v;
    end
    d = {b[31], (b[30:23] == 8'hFF) ? 11'h7FF : 11'(b[30:23] + 11'd896), b[22:0], 29'b0};
    return $bitstoreal(d);
  endfunction

  // real to binary32 pattern, round to nearest even, subnormals kept
  function automatic logic [31:0] real_to_sp(real v);
    logic [63:0] d;
    logic [63:0] sig;
    logic [31:0] q;
    int          ue;
    int          sh;
    logic        up;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, d[51], d[50:29] | {21'b0, |d[51:0] & ~d[51]}};
    if (d[62:52] == 11'd0) return {d[63], 31'b0};
    ue = int'(d[62:52]) - 1023;
    if (ue > 127) return {d[63], 8'hFF, 23'b0};
    if (ue >= -126) begin
      up = d[28] & ((|d[27:0]) | d[29]);
      return {d[63], 8'(ue + 127), d[51:29]} + {31'b0, up};
    end
    sig = {11'b0, 1'b1, d[51:0]};
    sh  = -(ue + 97);
    if (sh > 54) return {d[63], 31'b0};
    q  = 32'(sig >> sh);
    up = sig[sh-1] & (((sig & ((64'd1 << (sh - 1)) - 1)) != 0) | q[0]);
    return {d[63], 31'b0} | (q + {31'b0, up});
  endfunction

  // one-rounding fused multiply-add: exact product, sum rounded to odd
  function automatic logic [31:0] fma_sp(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    real         p, c, s, bv, av, err;
    logic [63:0] b;
    p   = sp_to_real(x) * sp_to_real(y);
    c   = sp_to_real(z);
    s   = p + c;
    bv  = s - p;
    av  = s - bv;
    err = (p - av) + (c - bv);
    if (err != 0.0 && (s - s) == 0.0) begin
      b = $realtobits(s);
      if (!b[0]) begin
        if ((err > 0.0) == (s > 0.0)) b = b + 64'd1;
        else b = b - 64'd1;
        s = $bitstoreal(b);
      end
    end
    return real_to_sp(s);
  endfunction

  function automatic logic [31:0] mul_sp(logic [31:0] x, logic [31:0] y);
    return real_to_sp(sp_to_real(x) * sp_to_real(y));
  endfunction

  function automatic logic [31:0] k(real v);
    return real_to_sp(v);
  endfunction

  // natural log of a positive finite binary32 value
  function automatic logic [31:0] ln_sp(logic [31:0] x);
    logic [22:0] frac;
    int          e;
    logic [31:0] m, ib, s, r, t;
    frac = x[22:0];
    if (x[30:23] == 8'd0) begin
      e = -125;
      while (!frac[22] && frac != 0) begin
        frac = frac << 1;
        e--;
      end
      frac = frac << 1;
      e--;
    end else begin
      e = int'(x[30:23]) - 126;
    end
    m = {9'h07E, frac};
    // fold mantissa into [2/3, 4/3)
    if (sp_to_real(m) < sp_to_real(k(0.666666667))) begin
      m = real_to_sp(sp_to_real(m) * 2.0);
      e--;
    end
    ib = real_to_sp(real'(e));
    m  = real_to_sp(sp_to_real(m) - 1.0);
    s  = mul_sp(m, m);
    r  = k(-0.130310059);
    t  = k(0.140869141);
    r  = fma_sp(r, s, k(-0.121484190));
    t  = fma_sp(t, s, k(0.139814854));
    r  = fma_sp(r, s, k(-0.166846052));
    t  = fma_sp(t, s, k(0.200120345));
    r  = fma_sp(r, s, k(-0.249996200));
    r  = fma_sp(t, m, r);
    r  = fma_sp(r, m, k(0.333331972));
    r  = fma_sp(r, m, k(-0.5));
    r  = fma_sp(r, s, m);
    return fma_sp(ib, k(0.693147182), r);
  endfunction

  // expected erfinv pattern for one operand
  function automatic logic [31:0] erfinv_of(logic [31:0] ab, output bit wide);
    logic [30:0] mag;
    logic [31:0] t, p;
    real         wide_c[9];
    real         narrow_c[10];
    wide_c   = '{3.03697567e-10, 2.93243101e-8, 1.22150334e-6, 2.84108955e-5,
                 3.93552968e-4, 3.02698812e-3, 4.83185798e-3, -2.64646143e-1,
                 8.40016484e-1};
    narrow_c = '{5.43877832e-9, 1.43285448e-7, 1.22774793e-6, 1.12963626e-7,
                 -5.61530760e-5, -1.47697632e-4, 2.31468678e-3, 1.15392581e-2,
                 -2.32015476e-1, 8.86226892e-1};
    wide = 0;
    mag  = ab[30:0];
    if (mag > 31'h7F800000) return ab | 32'h00400000;
    if (mag > 31'h3F800000) return QNan;
    if (mag == 31'h3F800000) return {ab[31], 31'h7F800000};
    t = fma_sp(ab, {~ab[31], ab[30:0]}, One);
    t = ln_sp(t);
    if ((sp_to_real(t) < 0.0 ? -sp_to_real(t) : sp_to_real(t)) > 6.125) begin
      wide = 1;
      p = k(wide_c[0]);
      for (int j = 1; j < 9; j++) p = fma_sp(p, t, k(wide_c[j]));
    end else begin
      p = k(narrow_c[0]);
      for (int j = 1; j < 10; j++) p = fma_sp(p, t, k(narrow_c[j]));
    end
    return mul_sp(ab, p);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // operand mix: mostly in [-1, 1], a good share near one, some noise
  function automatic logic [31:0] random_operand();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom;
      1: return {1'($urandom), 8'd126, 23'h7FFFFF - 23'($urandom_range(0, 65535))};
      8: return {1'($urandom), 8'($urandom_range(0, 99)), 23'($urandom)};
      9: begin
        case ($urandom_range(0, 3))
          0: return {1'($urandom), 31'h3F800000};
          1: return {1'($urandom), 31'h0};
          2: return {1'($urandom), 31'h3F800000 + 31'($urandom_range(1, 1000))};
          default: return {1'($urandom), 8'd0, 23'($urandom)};
        endcase
      end
      default: return {1'($urandom), 8'($urandom_range(100, 126)), 23'($urandom)};
    endcase
  endfunction

  // sender: next beat goes out at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      beat_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (operand_q.size() > 0) begin
        operand_bits_i <= operand_q.pop_front();
        in_valid_i     <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= (stall_left > 0);
    end
  end

  // input beats feed the prediction, output beats are checked against it
  always @(posedge clk_i) begin
    bit w;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      erfinv_q.push_back(erfinv_of(operand_bits_i, w));
      wide_hits  += w;
      beats_in++;
      beat_taken = 1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (erfinv_q.size() == 0) begin
        $error("result_bits: no result expected, actual %h", result_bits_o);
        errors++;
      end else if (erfinv_q[0] !== result_bits_o) begin
        $error("result_bits: expected %h, actual %h", erfinv_q[0], result_bits_o);
        errors++;
        void'(erfinv_q.pop_front());
      end else begin
        void'(erfinv_q.pop_front());
      end
    end
  end

  task automatic drain();
    while (operand_q.size() > 0 || in_valid_i || erfinv_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] directed[] = '{
      32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000, 32'h7F800000,
      32'hFF800000, 32'h7FC00000, 32'h7F800001, 32'hFFA12345, 32'h3F800001,
      32'hBF800001, 32'h00000001, 32'h80000001, 32'h007FFFFF, 32'h3F7FFFFF,
      32'hBF7FFFFF, 32'h3F000000, 32'h3F7FF000, 32'h3E800000, 32'h3DCCCCCD,
      32'hBF400000, 32'h40000000, 32'h7F7FFFFF, 32'h33800000};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    foreach (directed[j]) operand_q.push_back(directed[j]);
    repeat (600) operand_q.push_back(random_operand());
    drain();
    // back-to-back stretch after a full pause of the sender
    no_idle = 1;
    repeat (300) operand_q.push_back(random_operand());
    drain();
    no_idle = 0;
    // long receiver hold while the sender keeps offering
    hold_req = 1;
    repeat (700) operand_q.push_back(random_operand());
    drain();
    repeat (200) @(posedge clk_i);
    $display("Checked %0d operands, %0d results; %0d took the wide-argument branch.",
             beats_in, beats_out, wide_hits);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule
